// ===== src/kbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard scan FIFO package
// Shared types and constants for the keyboard scan FIFO and serial port.
// ----------------------------------------------------------------------------
package kbsf_pkg;

  localparam logic [3:0] PHASE_IDLE = 4'd15;
  localparam logic [3:0] PHASE_COMMIT = 4'd9;
  localparam logic [3:0] PHASE_LAST = 4'd11;
  localparam logic [11:0] EV_MAKE = 12'h800;
  localparam logic [11:0] EV_BREAK = 12'h100;
  localparam logic [3:0] SCROLL_LOCK_MASK = 4'h1;
  localparam logic [3:0] CAPS_LOCK_MASK = 4'h4;
  localparam logic [7:0] CODE_SCROLL = 8'h7E;
  localparam logic [7:0] CODE_CAPS = 8'h58;
  localparam logic [7:0] HOST_BITS = 8'hE0;
  localparam logic [0:0] CFG_DELAY = 1'b0;
  localparam logic [0:0] CFG_PERIOD = 1'b1;
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_BUS = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [1:0] word_index;
    logic [63:0] key_bits;
    logic [7:0] port_out;
    logic [7:0] port_driven;
  } in_word_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic [4:0] fifo_level;
    logic       scan_dropped;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input item
    logic scan_init;  // begin a scan: drop flag handling, diff setup
    logic scan_step;  // examine one bit of the diff
    logic pop_req;    // read FIFO head for a frame start
    logic bus_exec;   // perform bus access (uses registered FIFO read)
    logic finish;     // form the result word
  } kbsf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_scan;
    logic scan_active;
    logic scan_done;
    logic need_pop;
  } kbsf_sts_t;

  // Pad button index for a key code; 5'h1F means no button.
  function automatic logic [4:0] button_of(input logic [7:0] code);
    logic [4:0] b;
    b = 5'h1F;
    unique case (code)
      8'h89: b = 5'd0;
      8'h8A: b = 5'd1;
      8'h86: b = 5'd2;
      8'h8D: b = 5'd3;
      8'h22: b = 5'd4;
      8'h21: b = 5'd5;
      8'h1A: b = 5'd6;
      8'h76: b = 5'd7;
      8'h23: b = 5'd8;
      8'h1B: b = 5'd9;
      8'h1C: b = 5'd10;
      8'h24: b = 5'd11;
      8'h15: b = 5'd15;
      default: b = 5'h1F;
    endcase
    return b;
  endfunction

  // Button cleared along with a pressed one (opposite direction); 5'h1F none.
  function automatic logic [4:0] other_of(input logic [4:0] b);
    logic [4:0] o;
    unique case (b)
      5'd0: o = 5'd1;
      5'd1: o = 5'd0;
      5'd2: o = 5'd3;
      5'd3: o = 5'd2;
      default: o = 5'h1F;
    endcase
    return o;
  endfunction

endpackage

// ===== src/kbsf_if.sv =====
// ----------------------------------------------------------------------------
// Keyboard scan FIFO channel
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface kbsf_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/kbsf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module kbsf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/kbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyboard scan FIFO controller
// Sequences the load, the bit-serial scan, the FIFO read and the result.
// ----------------------------------------------------------------------------
module kbsf_ctrl
  import kbsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  kbsf_sts_t sts,
  output kbsf_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_READ, S_BUS, S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_IDLE:   ;
      S_DECODE: begin
        cmd.scan_init = sts.is_scan;
        cmd.pop_req = !sts.is_scan;
      end
      S_SCAN:   cmd.scan_step = 1'b1;
      S_READ:   cmd.bus_exec = 1'b0;
      S_BUS:    cmd.bus_exec = 1'b1;
      S_DONE:   cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (cmd.load) state <= S_DECODE;
        S_DECODE: state <= sts.is_scan ? S_SCAN : S_READ;
        S_SCAN:   if (sts.scan_done) state <= S_DONE;
        S_READ:   state <= S_BUS;
        S_BUS:    state <= S_DONE;
        S_DONE: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && state == S_DONE))
    else $error("result pending while another completes");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input taken outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");
endmodule

// ===== src/kbsf_dp.sv =====
// ----------------------------------------------------------------------------
// Keyboard scan FIFO datapath
// Key state compare, event FIFO, frame sequencer and port read-back.
// ----------------------------------------------------------------------------
module kbsf_dp
  import kbsf_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index_lo,
  input  logic       cfg_index_hi_zero,
  input  logic [7:0] cfg_data,
  input  in_word_t   in_data,
  input  kbsf_cmd_t  cmd,
  output kbsf_sts_t  sts,
  output out_word_t  out_data
);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  in_word_t item;
  logic [7:0] repeat_delay, repeat_period;
  logic [63:0] seen [3];
  logic [63:0] diff;
  logic [63:0] bits_m;
  logic [5:0] bitpos;
  logic scanning;
  logic drop_flag;
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;
  logic [11:0] fifo_rdata;
  logic fifo_we;
  logic [11:0] fifo_wdata;
  logic [15:0] pad, pad_next;
  logic [3:0] lock, lock_next;
  logic [11:0] pending;
  logic [7:0] rkey, rkey_next, rcount, rcount_next;
  logic [3:0] nib [12];
  logic [3:0] data_nibble;
  logic ack_line;
  logic [3:0] phase;
  logic [7:0] bus_data;
  logic [1:0] grp;

  assign grp = item.word_index;

  kbsf_ram #(.WIDTH(12), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .we(fifo_we), .waddr(wr_ptr), .wdata(fifo_wdata),
    .raddr(rd_ptr), .rdata(fifo_rdata)
  );

  logic cur_diff, cur_new, full;
  assign cur_diff = diff[bitpos];
  assign cur_new = bits_m[bitpos];
  assign full = (count == CW'(FIFO_DEPTH));
  assign fifo_we = cmd.scan_step && scanning && cur_diff && !full;
  assign fifo_wdata = (cur_new ? EV_MAKE : EV_BREAK) | {4'h0, grp, bitpos};

  assign sts.is_scan = (item.operation == OP_SCAN);
  assign sts.scan_active = scanning;
  assign sts.scan_done = !scanning || (bitpos == 6'd0) || (cur_diff && full);
  assign sts.need_pop = (pending[11:8] == 4'h0) && (count != '0);

  // Bus access step: toggle decision and new phase.
  logic toggle, advance;
  logic [3:0] phase_new;
  assign toggle = (item.port_out[5] != ack_line);
  assign advance = (phase == PHASE_IDLE) || (phase < PHASE_LAST);
  assign phase_new = !advance ? phase :
                     (phase == PHASE_IDLE) ? 4'd0 : phase + 4'd1;

  // Frame start computation.
  logic [11:0] pend_fs;
  logic [15:0] padn_fs;
  logic [3:0] lockn_fs;
  logic [7:0] rkeyn_fs, rcountn_fs;
  logic pop_fs;
  always_comb begin
    logic p;
    logic [7:0] code;
    logic [4:0] b, o;
    logic [15:0] v;
    logic [7:0] dec;
    pend_fs = pending;
    padn_fs = pad_next;
    lockn_fs = lock_next;
    rkeyn_fs = rkey_next;
    rcountn_fs = rcount_next;
    pop_fs = 1'b0;
    p = 1'b0;
    code = '0;
    b = '0;
    o = '0;
    v = '0;
    dec = rcount - 8'd1;
    if (pending[11:8] == 4'h0) begin
      if (count != '0) begin
        pop_fs = 1'b1;
        pend_fs = fifo_rdata;
        p = fifo_rdata[11];
        code = fifo_rdata[7:0];
        if (p) begin
          rkeyn_fs = code;
          rcountn_fs = repeat_delay;
        end else if (rkey == code) begin
          rcountn_fs = 8'd0;
        end
        b = button_of(code);
        o = other_of(b);
        if (b != 5'h1F) begin
          v = pad & ~(16'd1 << b[3:0]);
          if (p && o != 5'h1F) v = v & ~(16'd1 << o[3:0]);
          if (p) v = v | (16'd1 << b[3:0]);
          padn_fs = v;
        end else if (code == CODE_SCROLL) begin
          lockn_fs = lock ^ (p ? SCROLL_LOCK_MASK : 4'h0);
        end else if (code == CODE_CAPS) begin
          lockn_fs = lock ^ (p ? CAPS_LOCK_MASK : 4'h0);
        end
      end else if (rcount != 8'd0) begin
        rcountn_fs = dec;
        if (dec == 8'd0) begin
          pend_fs = EV_MAKE | {4'h0, rkey};
          rcountn_fs = repeat_period;
        end
      end
    end
  end

  always_comb begin
    logic [7:0] drv;
    drv = item.port_driven;
    bus_data = (item.port_out & (drv | HOST_BITS)) |
               ({3'b000, ack_line, data_nibble} & ~drv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= 8'd30;
      repeat_period <= 8'd6;
      for (int g = 0; g < 3; g++) seen[g] <= '0;
      drop_flag <= 1'b0;
      scanning <= 1'b0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
      pad <= '0;
      pad_next <= '0;
      lock <= '0;
      lock_next <= '0;
      pending <= '0;
      rkey <= '0;
      rkey_next <= '0;
      rcount <= '0;
      rcount_next <= '0;
      for (int i = 0; i < 12; i++) nib[i] <= '0;
      data_nibble <= 4'd1;
      ack_line <= 1'b1;
      phase <= PHASE_IDLE;
      out_data <= '0;
    end else begin
      if (cfg_we && cfg_index_hi_zero) begin
        if (cfg_index_lo == CFG_DELAY) repeat_delay <= cfg_data;
        else repeat_period <= cfg_data;
      end
      if (cmd.load) item <= in_data;
      if (cmd.scan_init) begin
        logic dflag;
        logic [63:0] b;
        dflag = (grp == 2'd0) ? 1'b0 : drop_flag;
        drop_flag <= dflag;
        b = (grp == 2'd2) ? {48'h0, item.key_bits[15:0]} : item.key_bits;
        bits_m <= b;
        scanning <= (grp != 2'd3) && !dflag;
        diff <= (grp == 2'd3) ? '0 : (b ^ seen[grp]);
        bitpos <= 6'd63;
      end
      if (cmd.scan_step) begin
        if (scanning && cur_diff) begin
          if (full) begin
            drop_flag <= 1'b1;
          end else begin
            wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
            count <= count + CW'(1);
            seen[grp][bitpos] <= cur_new;
          end
        end
        if (sts.scan_done) scanning <= 1'b0;
        bitpos <= bitpos - 6'd1;
      end
      if (cmd.bus_exec) begin
        if (item.port_out[6]) begin
          phase <= PHASE_IDLE;
          ack_line <= 1'b1;
          data_nibble <= 4'd1;
        end else if (toggle) begin
          if (advance) ack_line <= ~ack_line;
          phase <= phase_new;
          if (phase_new == 4'd0) begin
            pending <= pend_fs;
            pad_next <= padn_fs;
            lock_next <= lockn_fs;
            rkey_next <= rkeyn_fs;
            rcount_next <= rcountn_fs;
            if (pop_fs) begin
              rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
              count <= count - CW'(1);
            end
            nib[0] <= 4'h3;
            nib[1] <= 4'h4;
            nib[2] <= ~padn_fs[3:0];
            nib[3] <= ~padn_fs[7:4];
            nib[4] <= ~padn_fs[11:8];
            nib[5] <= {~padn_fs[15], 3'b000};
            nib[6] <= lockn_fs;
            nib[7] <= pend_fs[11:8] | 4'h6;
            nib[8] <= pend_fs[7:4];
            nib[9] <= pend_fs[3:0];
            nib[10] <= 4'h0;
            nib[11] <= 4'h1;
            data_nibble <= 4'h3;
          end else if (phase_new == PHASE_COMMIT) begin
            pending <= {4'h0, pending[7:0]};
            lock <= lock_next;
            pad <= pad_next;
            rcount <= rcount_next;
            rkey <= rkey_next;
            data_nibble <= nib[phase_new];
          end else begin
            data_nibble <= nib[phase_new];
          end
        end
      end
      if (cmd.finish) begin
        out_data.bus_data <= (item.operation == OP_BUS) ? bus_data : 8'h00;
        out_data.fifo_level <= 5'(count);
        out_data.scan_dropped <= drop_flag;
      end
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("FIFO count overflow");
  a_no_full_write: assert property (@(posedge clk) disable iff (rst)
    !(fifo_we && full))
    else $error("write into full FIFO");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan_step && cmd.bus_exec))
    else $error("scan and bus overlap");
endmodule

// ===== src/keyboard_scan_fifo_serial_port_top.sv =====
// ----------------------------------------------------------------------------
// Keyboard scan FIFO serial port top
// Channel  | Dir | Payload
// in_ch    | in  | operation, word_index, key_bits, port_out, port_driven
// out_ch   | out | bus_data, fifo_level, scan_dropped
// cfg      | in  | cfg_we, cfg_index, cfg_data (repeat_delay, repeat_period)
// A scan word is examined one key bit per cycle, stopping early
// when the FIFO fills. A bus access passes through the decode, read, bus and
// done states, the read state being spent on the FIFO RAM read.
// Reset is synchronous; no clearing pass is needed.
// A result waits in the output register; the next item is taken once it is
// taken or in the same cycle.
// ----------------------------------------------------------------------------
module keyboard_scan_fifo_serial_port_top
  import kbsf_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  kbsf_if.sink       in_ch,
  kbsf_if.source     out_ch
);
  kbsf_cmd_t cmd;
  kbsf_sts_t sts;
  out_word_t res;

  kbsf_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  kbsf_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index_lo(cfg_index), .cfg_index_hi_zero(1'b1),
    .cfg_data(cfg_data), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
    .out_data(res)
  );

  assign out_ch.data = res;
endmodule
